>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks for simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define OTSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define OTSU_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define OTSU_ASSERT(label, clk, rst, prop, msg)
`define OTSU_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> sv/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared widths, codes, state encoding and interface structs of the core.
// ----------------------------------------------------------------------------
package otsu_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int BIN_BITS   = 8;
   localparam int HIST_BINS  = 256;
   localparam int CNT_BITS   = 23;
   localparam int SUM_BITS   = 30;
   localparam int PROD_BITS  = 52;
   localparam int Q_BITS     = 44;
   localparam int MUL_A_BITS = 2 * PROD_BITS;
   localparam int MUL_B_BITS = PROD_BITS;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int DIV_N_BITS = PIXEL_BITS + BIN_BITS;

   localparam logic [BIN_BITS-1:0]   BIN_LAST   = BIN_BITS'(HIST_BINS - 1);
   localparam logic [CNT_BITS-1:0]   MAX_PIXELS = CNT_BITS'(4194304);
   localparam logic [PIXEL_BITS-1:0] PIX_ONES   = '1;

   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_HIST = 1'b1;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_BIN,
      BK_DIV,
      BK_READ,
      BK_UPDATE,
      BK_LAST,
      BK_SUM_RD,
      BK_SUM_ACC,
      BK_SCAN_RD,
      BK_SCAN_ACC,
      BK_PROD,
      BK_DIFF,
      BK_SQ,
      BK_CMP,
      BK_THR,
      BK_THR_EST,
      BK_THR_FIX,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last;
   } hist_item_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] min_val;
      logic [PIXEL_BITS-1:0] max_val;
   } bounds_type;

   typedef struct packed {
      logic busy;
      logic clear;
   } back_status_type;

endpackage

>>> sv/otsu_fifo.sv
// ----------------------------------------------------------------------------
// otsu_fifo
// Two-entry queue of histogram requests between front and back.
// ----------------------------------------------------------------------------
module otsu_fifo
   import otsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hist_item_type push_item,
   input  logic          pop,
   output hist_item_type head_item,
   output logic          full,
   output logic          empty
);

   hist_item_type entry_ff [2];
   hist_item_type entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_item;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign full      = count_ff[1];
   assign empty     = (count_ff == 2'd0);

endmodule

>>> sv/otsu_front.sv
// ----------------------------------------------------------------------------
// otsu_front
// Accepts requests, tracks the scan-pass extremes, queues histogram pixels.
// ----------------------------------------------------------------------------
module otsu_front
   import otsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   input  logic                  req_last,
   input  logic                  fifo_full,
   input  logic                  fifo_empty,
   input  back_status_type       bk_status,
   output logic                  push,
   output hist_item_type         push_item,
   output bounds_type            bounds
);

   logic [PIXEL_BITS-1:0] min_ff, min_in;
   logic [PIXEL_BITS-1:0] max_ff, max_in;
   logic                  scan_ok;
   logic                  accept;

   // a scan pixel must wait until every earlier histogram pixel is done
   assign scan_ok   = fifo_empty && !bk_status.busy;
   assign req_stall = fifo_full || (req_cmd == CMD_SCAN && !scan_ok);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_cmd == CMD_HIST);
   assign push_item = '{pixel: req_pixel, last: req_last};

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (bk_status.clear) begin
         min_in = PIX_ONES;
         max_in = '0;
      end else if (accept && req_cmd == CMD_SCAN) begin
         if (req_pixel < min_ff) begin
            min_in = req_pixel;
         end
         if (req_pixel > max_ff) begin
            max_in = req_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= PIX_ONES;
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign bounds = '{min_val: min_ff, max_val: max_ff};

endmodule

>>> sv/otsu_div.sv
// ----------------------------------------------------------------------------
// otsu_div
// Restoring divider, one quotient bit a cycle; numerator below den * 2^16.
// ----------------------------------------------------------------------------
module otsu_div
   import otsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_N_BITS-1:0] num,
   input  logic [PIXEL_BITS-1:0] den,
   output logic                  busy,
   output logic [PIXEL_BITS-1:0] quot
);

   logic                  busy_ff, busy_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [PIXEL_BITS-1:0] rem_ff, rem_in;
   logic [PIXEL_BITS-1:0] low_ff, low_in;
   logic [PIXEL_BITS-1:0] quot_ff, quot_in;
   logic [PIXEL_BITS-1:0] den_ff, den_in;
   logic [PIXEL_BITS:0]   trial;
   logic                  fits;

   assign trial = {rem_ff, low_ff[PIXEL_BITS-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {{(PIXEL_BITS - BIN_BITS){1'b0}}, num[DIV_N_BITS-1:PIXEL_BITS]};
         low_in  = num[PIXEL_BITS-1:0];
         quot_in = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? PIXEL_BITS'(trial - {1'b0, den_ff}) : trial[PIXEL_BITS-1:0];
         low_in  = {low_ff[PIXEL_BITS-2:0], 1'b0};
         quot_in = {quot_ff[PIXEL_BITS-2:0], fits};
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

>>> sv/otsu_smul.sv
// ----------------------------------------------------------------------------
// otsu_smul
// Shift-add multiplier, one multiplier bit a cycle, full-width product.
// ----------------------------------------------------------------------------
module otsu_smul
   import otsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [MUL_A_BITS-1:0] a,
   input  logic [MUL_B_BITS-1:0] b,
   output logic                  busy,
   output logic [MUL_P_BITS-1:0] prod
);

   logic                  busy_ff, busy_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [MUL_P_BITS-1:0] acc_ff, acc_in;
   logic [MUL_P_BITS-1:0] a_sh_ff, a_sh_in;
   logic [MUL_B_BITS-1:0] b_sh_ff, b_sh_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_sh_in = {{MUL_B_BITS{1'b0}}, a};
         b_sh_in = b;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = {a_sh_ff[MUL_P_BITS-2:0], 1'b0};
         b_sh_in = {1'b0, b_sh_ff[MUL_B_BITS-1:1]};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'(MUL_B_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

>>> sv/otsu_back.sv
// ----------------------------------------------------------------------------
// otsu_back
// Bins histogram pixels, runs the Otsu search and delivers the threshold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otsu_back
   import otsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fifo_empty,
   input  hist_item_type         head_item,
   input  bounds_type            bounds,
   output logic                  pop,
   output back_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIXEL_BITS-1:0] rsp_threshold,
   output logic [BIN_BITS-1:0]   rsp_peak_bin,
   output logic                  rsp_flat_image
);

   back_state_type state_ff, state_in;
   hist_item_type  item_ff, item_in;

   logic [CNT_BITS-1:0]   total_ff, total_in;
   logic [HIST_BINS-1:0]  vld_ff, vld_in;
   logic [BIN_BITS-1:0]   bin_ff, bin_in;
   logic [BIN_BITS-1:0]   rd_addr_ff, rd_addr_in;
   logic [CNT_BITS-1:0]   rd_data_ff;
   logic [CNT_BITS-1:0]   hist_mem [HIST_BINS];
   logic                  mem_we;
   logic [CNT_BITS-1:0]   mem_wd;

   logic [BIN_BITS-1:0]   idx_ff, idx_in;
   logic [SUM_BITS-1:0]   s_ff, s_in;
   logic [SUM_BITS-1:0]   sb_ff, sb_in;
   logic [CNT_BITS-1:0]   wb_ff, wb_in;
   logic [PROD_BITS-1:0]  a1_ff, a1_in;
   logic [PROD_BITS-1:0]  a2_ff, a2_in;
   logic [Q_BITS-1:0]     q_ff, q_in;
   logic [MUL_A_BITS-1:0] d2_ff, d2_in;
   logic                  have_ff, have_in;
   logic [BIN_BITS-1:0]   best_ff, best_in;
   logic [MUL_A_BITS-1:0] best_d2_ff, best_d2_in;
   logic [Q_BITS-1:0]     best_q_ff, best_q_in;
   logic [DIV_N_BITS-1:0] tn_ff, tn_in;
   logic [PIXEL_BITS-1:0] tq_ff, tq_in;

   logic [PIXEL_BITS-1:0] res_thr_ff, res_thr_in;
   logic [BIN_BITS-1:0]   res_bin_ff, res_bin_in;
   logic                  res_flat_ff, res_flat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] rsp_thr_ff, rsp_thr_in;
   logic [BIN_BITS-1:0]   rsp_bin_ff, rsp_bin_in;
   logic                  rsp_flat_ff, rsp_flat_in;

   logic                  div_start, div_busy;
   logic [DIV_N_BITS-1:0] div_num;
   logic [PIXEL_BITS-1:0] div_den, div_quot;
   logic                  mul_l_start, mul_l_busy, mul_r_start, mul_r_busy;
   logic [MUL_A_BITS-1:0] mul_l_a, mul_r_a;
   logic [MUL_B_BITS-1:0] mul_l_b, mul_r_b;
   logic [MUL_P_BITS-1:0] mul_l_prod, mul_r_prod;

   logic                  clear;
   logic                  step_bin;
   logic [CNT_BITS-1:0]   cnt;
   logic [PIXEL_BITS-1:0] spread;
   logic [PIXEL_BITS-1:0] offset;
   logic [DIV_N_BITS-1:0] scaled;
   logic [DIV_N_BITS-1:0] thr_num;
   logic [DIV_N_BITS:0]   tq_sum;
   logic [DIV_N_BITS-1:0] tq_x255;
   logic [DIV_N_BITS-1:0] tq_rem;
   logic [SUM_BITS-1:0]   idx_w, cnt_w, bin_term;
   logic [CNT_BITS-1:0]   wb_next;
   logic [PROD_BITS-1:0]  sb_x, s_x, n_x, wb_x;
   logic [2*CNT_BITS-1:0] wbq_x, wfq_x, q_full;
   logic [PROD_BITS-1:0]  d;

   // count of the bin that was read last cycle; a bin not yet written is zero
   assign cnt      = vld_ff[rd_addr_ff] ? rd_data_ff : '0;
   assign spread   = bounds.max_val - bounds.min_val;
   assign offset   = item_ff.pixel - bounds.min_val;
   assign scaled   = {offset, {BIN_BITS{1'b0}}} - {{BIN_BITS{1'b0}}, offset};
   assign thr_num  = DIV_N_BITS'(best_ff) * DIV_N_BITS'(spread);
   // x / 255 from x/256 + x/2^16 + x/2^24; low by at most one, fixed below
   assign tq_sum   = (DIV_N_BITS+1)'(tn_ff) + (DIV_N_BITS+1)'(tn_ff >> BIN_BITS)
                   + (DIV_N_BITS+1)'(tn_ff >> (2*BIN_BITS));
   assign tq_x255  = {tq_ff, {BIN_BITS{1'b0}}} - DIV_N_BITS'(tq_ff);
   assign tq_rem   = tn_ff - tq_x255;
   assign idx_w    = SUM_BITS'(idx_ff);
   assign cnt_w    = SUM_BITS'(cnt);
   assign bin_term = idx_w * cnt_w;
   assign wb_next  = wb_ff + cnt;
   assign sb_x     = PROD_BITS'(sb_ff);
   assign s_x      = PROD_BITS'(s_ff);
   assign n_x      = PROD_BITS'(total_ff);
   assign wb_x     = PROD_BITS'(wb_ff);
   assign wbq_x    = (2*CNT_BITS)'(wb_ff);
   assign wfq_x    = (2*CNT_BITS)'(total_ff - wb_ff);
   assign q_full   = wbq_x * wfq_x;
   assign d        = (a1_ff >= a2_ff) ? (a1_ff - a2_ff) : (a2_ff - a1_ff);

   assign div_num = scaled;
   assign div_den = spread;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      total_in     = total_ff;
      vld_in       = vld_ff;
      bin_in       = bin_ff;
      rd_addr_in   = idx_ff;
      idx_in       = idx_ff;
      s_in         = s_ff;
      sb_in        = sb_ff;
      wb_in        = wb_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      q_in         = q_ff;
      d2_in        = d2_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_d2_in   = best_d2_ff;
      best_q_in    = best_q_ff;
      tn_in        = tn_ff;
      tq_in        = tq_ff;
      res_thr_in   = res_thr_ff;
      res_bin_in   = res_bin_ff;
      res_flat_in  = res_flat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_thr_in   = rsp_thr_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_flat_in  = rsp_flat_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wd       = cnt + CNT_BITS'(1);
      div_start    = 1'b0;
      mul_l_start  = 1'b0;
      mul_l_a      = PROD_BITS'(d) == d ? MUL_A_BITS'(d) : '0;
      mul_l_b      = d;
      mul_r_start  = 1'b0;
      mul_r_a      = best_d2_ff;
      mul_r_b      = MUL_B_BITS'(q_ff);
      clear        = 1'b0;
      step_bin     = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               item_in  = head_item;
               state_in = BK_BIN;
            end
         end
         BK_BIN: begin
            if (total_ff < MAX_PIXELS) begin
               if (bounds.max_val > bounds.min_val && item_ff.pixel > bounds.min_val) begin
                  if (item_ff.pixel >= bounds.max_val) begin
                     bin_in   = BIN_LAST;
                     state_in = BK_READ;
                  end else begin
                     div_start = 1'b1;
                     state_in  = BK_DIV;
                  end
               end else begin
                  bin_in   = '0;
                  state_in = BK_READ;
               end
            end else begin
               state_in = item_ff.last ? BK_LAST : BK_IDLE;
            end
         end
         BK_DIV: begin
            if (!div_busy) begin
               bin_in   = div_quot[BIN_BITS-1:0];
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            rd_addr_in = bin_ff;
            state_in   = BK_UPDATE;
         end
         BK_UPDATE: begin
            mem_we         = 1'b1;
            vld_in[bin_ff] = 1'b1;
            total_in       = total_ff + CNT_BITS'(1);
            state_in       = item_ff.last ? BK_LAST : BK_IDLE;
         end
         BK_LAST: begin
            if (bounds.max_val <= bounds.min_val) begin
               res_thr_in  = bounds.min_val;
               res_bin_in  = '0;
               res_flat_in = 1'b1;
               state_in    = BK_OUT;
            end else begin
               idx_in   = '0;
               s_in     = '0;
               state_in = BK_SUM_RD;
            end
         end
         BK_SUM_RD: begin
            state_in = BK_SUM_ACC;
         end
         BK_SUM_ACC: begin
            s_in = s_ff + bin_term;
            if (idx_ff == BIN_LAST) begin
               idx_in   = '0;
               wb_in    = '0;
               sb_in    = '0;
               have_in  = 1'b0;
               best_in  = '0;
               state_in = BK_SCAN_RD;
            end else begin
               idx_in   = idx_ff + BIN_BITS'(1);
               state_in = BK_SUM_RD;
            end
         end
         BK_SCAN_RD: begin
            state_in = BK_SCAN_ACC;
         end
         BK_SCAN_ACC: begin
            if (wb_next == '0) begin
               step_bin = 1'b1;
            end else if (wb_next >= total_ff) begin
               state_in = BK_THR;
            end else begin
               wb_in    = wb_next;
               sb_in    = sb_ff + bin_term;
               state_in = BK_PROD;
            end
         end
         BK_PROD: begin
            a1_in    = sb_x * n_x;
            a2_in    = s_x * wb_x;
            q_in     = q_full[Q_BITS-1:0];
            state_in = BK_DIFF;
         end
         BK_DIFF: begin
            mul_l_start = 1'b1;
            state_in    = BK_SQ;
         end
         BK_SQ: begin
            if (!mul_l_busy) begin
               d2_in = mul_l_prod[MUL_A_BITS-1:0];
               if (!have_ff) begin
                  have_in    = 1'b1;
                  best_in    = idx_ff;
                  best_d2_in = mul_l_prod[MUL_A_BITS-1:0];
                  best_q_in  = q_ff;
                  step_bin   = 1'b1;
               end else begin
                  mul_l_start = 1'b1;
                  mul_l_a     = mul_l_prod[MUL_A_BITS-1:0];
                  mul_l_b     = MUL_B_BITS'(best_q_ff);
                  mul_r_start = 1'b1;
                  state_in    = BK_CMP;
               end
            end
         end
         BK_CMP: begin
            if (!mul_l_busy && !mul_r_busy) begin
               if (mul_l_prod > mul_r_prod) begin
                  best_in    = idx_ff;
                  best_d2_in = d2_ff;
                  best_q_in  = q_ff;
               end
               step_bin = 1'b1;
            end
         end
         BK_THR: begin
            tn_in    = thr_num;
            state_in = BK_THR_EST;
         end
         BK_THR_EST: begin
            tq_in    = tq_sum[BIN_BITS +: PIXEL_BITS];
            state_in = BK_THR_FIX;
         end
         BK_THR_FIX: begin
            res_thr_in  = bounds.min_val + tq_ff +
                          PIXEL_BITS'(tq_rem >= DIV_N_BITS'(BIN_LAST));
            res_bin_in  = best_ff;
            res_flat_in = 1'b0;
            state_in    = BK_OUT;
         end
         BK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_thr_in   = res_thr_ff;
               rsp_bin_in   = res_bin_ff;
               rsp_flat_in  = res_flat_ff;
               clear        = 1'b1;
               total_in     = '0;
               vld_in       = '0;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // advance to the next bin, or finish the search after the top bin
      if (step_bin) begin
         if (idx_ff == BIN_LAST) begin
            state_in = BK_THR;
         end else begin
            idx_in   = idx_ff + BIN_BITS'(1);
            state_in = BK_SCAN_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[bin_ff] <= mem_wd;
      end
      rd_data_ff <= hist_mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      bin_ff      <= bin_in;
      rd_addr_ff  <= rd_addr_in;
      idx_ff      <= idx_in;
      s_ff        <= s_in;
      sb_ff       <= sb_in;
      wb_ff       <= wb_in;
      a1_ff       <= a1_in;
      a2_ff       <= a2_in;
      q_ff        <= q_in;
      d2_ff       <= d2_in;
      best_ff     <= best_in;
      best_d2_ff  <= best_d2_in;
      best_q_ff   <= best_q_in;
      tn_ff       <= tn_in;
      tq_ff       <= tq_in;
      res_thr_ff  <= res_thr_in;
      res_bin_ff  <= res_bin_in;
      res_flat_ff <= res_flat_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_flat_ff <= rsp_flat_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         total_ff     <= '0;
         vld_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         vld_ff       <= vld_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   otsu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   otsu_smul u_mul_l (
      .clock (clock),
      .reset (reset),
      .start (mul_l_start),
      .a     (mul_l_a),
      .b     (mul_l_b),
      .busy  (mul_l_busy),
      .prod  (mul_l_prod)
   );

   otsu_smul u_mul_r (
      .clock (clock),
      .reset (reset),
      .start (mul_r_start),
      .a     (mul_r_a),
      .b     (mul_r_b),
      .busy  (mul_r_busy),
      .prod  (mul_r_prod)
   );

   assign status         = '{busy: (state_ff != BK_IDLE), clear: clear};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_threshold  = rsp_thr_ff;
   assign rsp_peak_bin   = rsp_bin_ff;
   assign rsp_flat_image = rsp_flat_ff;

   // a pixel strictly inside the extremes never lands in the top bin
   `OTSU_ASSERT(a_bin_below_top, clock, reset, (state_ff == BK_DIV && !div_busy) |-> (div_quot < PIXEL_BITS'(BIN_LAST)), "bin quotient out of range")
   // the pixel counter saturates at the image limit
   `OTSU_ASSERT(a_total_cap, clock, reset, (state_ff == BK_UPDATE) |-> (total_ff < MAX_PIXELS), "histogram update past pixel limit")
   // a result hand-off clears the histogram and leaves the result visible
   `OTSU_ASSERT(a_clear_done, clock, reset, status.clear |=> (total_ff == '0 && rsp_valid_ff && vld_ff == '0), "clear did not complete")
   // comparisons only run once a first candidate is held
   `OTSU_ASSERT(a_cmp_has_best, clock, reset, (state_ff == BK_CMP) |-> have_ff, "compare without a best candidate")
   // a candidate split always leaves pixels in the upper class
   `OTSU_ASSERT_NEVER(a_split_nonempty, clock, reset, (state_ff == BK_SQ && wb_ff >= total_ff), "candidate with empty upper class")

endmodule

>>> sv/otsu_histogram_threshold_core.sv
// ----------------------------------------------------------------------------
// otsu_histogram_threshold_core
// Two-pass Otsu threshold over a 256-bin histogram of 16-bit pixels.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  req_cmd, req_pixel, req_last
//   rsp_      out         rsp_valid/rsp_stall  rsp_threshold, rsp_peak_bin,
//                                              rsp_flat_image
//
// A scan request (cmd = 0) waits until the queue is empty and the back
// is idle. A histogram request strictly inside the extremes is binned
// by the restoring divider; pixels at or outside the extremes skip it.
// After the last histogram request the search runs: a weighted sum over
// all bins, then a pass per candidate bin on the two shift-add multipliers.
// Reset is synchronous; the histogram valid bits clear at once, no sweep.
// A stalled result holds in the output register while the front keeps
// queueing histogram requests (two-entry queue).
//
module otsu_histogram_threshold_core
   import otsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIXEL_BITS-1:0] rsp_threshold,
   output logic [BIN_BITS-1:0]   rsp_peak_bin,
   output logic                  rsp_flat_image
);

   // queue between front and back
   logic            push;
   logic            pop;
   logic            fifo_full;
   logic            fifo_empty;
   hist_item_type   push_item;
   hist_item_type   head_item;

   // extremes from the front, busy and clear from the back
   bounds_type      bounds;
   back_status_type bk_status;

   // accept requests, track min and max, queue histogram pixels
   otsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_pixel  (req_pixel),
      .req_last   (req_last),
      .fifo_full  (fifo_full),
      .fifo_empty (fifo_empty),
      .bk_status  (bk_status),
      .push       (push),
      .push_item  (push_item),
      .bounds     (bounds)
   );

   // hold histogram pixels until the back is free
   otsu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   // bin pixels, search, drive the result register
   otsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_empty     (fifo_empty),
      .head_item      (head_item),
      .bounds         (bounds),
      .pop            (pop),
      .status         (bk_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_threshold  (rsp_threshold),
      .rsp_peak_bin   (rsp_peak_bin),
      .rsp_flat_image (rsp_flat_image)
   );

endmodule

>>> tb/otsu_histogram_threshold_core_tb.sv
// ----------------------------------------------------------------------------
// otsu_histogram_threshold_core_tb
// Drives two-pass images into the Otsu core and checks every threshold
// result against an exact integer predictor with its own histogram state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otsu_histogram_threshold_core_tb;
   import otsu_pkg::*;

   typedef struct {
      logic [PIXEL_BITS-1:0] threshold;
      logic [BIN_BITS-1:0]   peak_bin;
      logic                  flat_image;
   } otsu_result_type;

   // Predictor and store of expected thresholds.
   class threshold_scoreboard;
      logic [PIXEL_BITS-1:0] lo_seen;
      logic [PIXEL_BITS-1:0] hi_seen;
      longint unsigned       counts [HIST_BINS];
      longint unsigned       binned;
      otsu_result_type       pending [$];
      int                    mismatches;
      int                    matched;

      function new();
         clear_image();
      endfunction

      function void clear_image();
         lo_seen = PIX_ONES;
         hi_seen = '0;
         foreach (counts[i]) counts[i] = 0;
         binned = 0;
      endfunction

      function int search_best();
         longint unsigned total, wsum, wb, sb, a1, a2, d, q, best_d, best_q;
         logic [191:0]    lhs, rhs;
         int              best;
         bit              have;
         total = binned; wsum = 0; wb = 0; sb = 0;
         best = 0; best_d = 0; best_q = 1; have = 0;
         for (int b = 0; b < HIST_BINS; b++) wsum += longint'(b) * counts[b];
         for (int b = 0; b < HIST_BINS; b++) begin
            wb += counts[b];
            if (wb == 0) continue;
            if (wb >= total) break;
            sb += longint'(b) * counts[b];
            a1 = sb * total;
            a2 = wsum * wb;
            d = (a1 > a2) ? a1 - a2 : a2 - a1;
            q = wb * (total - wb);
            if (!have) begin
               have = 1; best = b; best_d = d; best_q = q;
            end else begin
               lhs = 192'(d) * 192'(d) * 192'(best_q);
               rhs = 192'(best_d) * 192'(best_d) * 192'(q);
               if (lhs > rhs) begin
                  best = b; best_d = d; best_q = q;
               end
            end
         end
         return best;
      endfunction

      // Note an accepted request; a last histogram pixel queues a result.
      function void note_request(logic cmd, logic [PIXEL_BITS-1:0] pix, logic last);
         otsu_result_type  r;
         longint unsigned  bin, span;
         int               best;
         if (cmd == CMD_SCAN) begin
            if (pix < lo_seen) lo_seen = pix;
            if (pix > hi_seen) hi_seen = pix;
            return;
         end
         if (binned < longint'(MAX_PIXELS)) begin
            bin = 0;
            if (hi_seen > lo_seen && pix > lo_seen) begin
               if (pix >= hi_seen) bin = HIST_BINS - 1;
               else bin = (longint'(pix - lo_seen) * (HIST_BINS - 1)) /
                          longint'(hi_seen - lo_seen);
               if (bin > HIST_BINS - 1) bin = HIST_BINS - 1;
            end
            counts[bin]++;
            binned++;
         end
         if (!last) return;
         if (hi_seen <= lo_seen) begin
            r.threshold = lo_seen; r.peak_bin = '0; r.flat_image = 1'b1;
         end else begin
            best = search_best();
            span = longint'(hi_seen - lo_seen);
            r.threshold = PIXEL_BITS'(longint'(lo_seen) + (longint'(best) * span) / 255);
            r.peak_bin = BIN_BITS'(best);
            r.flat_image = 1'b0;
         end
         pending.push_back(r);
         clear_image();
      endfunction

      function void check_result(logic [PIXEL_BITS-1:0] thr, logic [BIN_BITS-1:0] bin,
                                 logic flat);
         otsu_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: threshold %0d bin %0d flat %0b", thr, bin, flat);
            return;
         end
         e = pending.pop_front();
         if (thr !== e.threshold || bin !== e.peak_bin || flat !== e.flat_image) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected thr %0d bin %0d flat %0b, got %0d %0d %0b",
                        e.threshold, e.peak_bin, e.flat_image, thr, bin, flat);
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = CMD_SCAN;
   logic [PIXEL_BITS-1:0] req_pixel = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIXEL_BITS-1:0] rsp_threshold;
   logic [BIN_BITS-1:0]   rsp_peak_bin;
   logic                  rsp_flat_image;

   threshold_scoreboard sb = new();
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int requests_sent  = 0;
   int images_sent    = 0;

   always #6 clock = ~clock;

   otsu_histogram_threshold_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_pixel     (req_pixel),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_threshold (rsp_threshold),
      .rsp_peak_bin  (rsp_peak_bin),
      .rsp_flat_image(rsp_flat_image)
   );

   // Receiver: check accepted results, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_threshold, rsp_peak_bin, rsp_flat_image);
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // Present one request, idling at random first; hold it until accepted.
   task automatic send_request(logic cmd, logic [PIXEL_BITS-1:0] pix, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_pixel <= pix;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(cmd, pix, last);
      requests_sent++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every queued threshold has come back.
   task automatic drain();
      drop_valid();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [PIXEL_BITS-1:0] pick(int lo, int hi);
      return PIXEL_BITS'($urandom_range(hi, lo));
   endfunction

   // One image: scan pass over [lo, hi] when do_scan is set, then histogram
   // pass, with a few pixels outside the scanned extremes.
   task automatic send_image(int lo, int hi, int nscan, int nhist, bit do_scan);
      if (do_scan) begin
         send_request(CMD_SCAN, PIXEL_BITS'(lo), 1'b0);
         for (int i = 0; i < nscan; i++)
            send_request(CMD_SCAN, pick(lo, hi), 1'b0);
         send_request(CMD_SCAN, PIXEL_BITS'(hi), 1'b1);
      end
      for (int i = 0; i < nhist; i++) begin
         if ($urandom_range(9) == 0)
            send_request(CMD_HIST, pick(0, 65535), i == nhist - 1);
         else
            send_request(CMD_HIST, pick(lo, hi), i == nhist - 1);
      end
      images_sent++;
   endtask

   initial begin
      int lo, hi, kind;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      rsp_stall_pct = 55;

      // Unscanned image: minimum stays all ones, flat result.
      send_request(CMD_HIST, 16'h1234, 1'b1);
      // Flat image.
      send_request(CMD_SCAN, 16'd500, 1'b0);
      send_request(CMD_SCAN, 16'd500, 1'b1);
      send_request(CMD_HIST, 16'd500, 1'b0);
      send_request(CMD_HIST, 16'd7, 1'b1);
      // Full range, every pixel in one bin: no candidate bin.
      send_request(CMD_SCAN, 16'd0, 1'b0);
      send_request(CMD_SCAN, 16'hFFFF, 1'b1);
      send_request(CMD_HIST, 16'd0, 1'b0);
      send_request(CMD_HIST, 16'd0, 1'b1);
      // Pixels below min and above max, plus in-range ones.
      send_request(CMD_SCAN, 16'd200, 1'b0);
      send_request(CMD_SCAN, 16'd100, 1'b1);
      send_request(CMD_HIST, 16'd50, 1'b0);
      send_request(CMD_HIST, 16'hFFFF, 1'b0);
      send_request(CMD_HIST, 16'd150, 1'b0);
      send_request(CMD_HIST, 16'd101, 1'b0);
      send_request(CMD_HIST, 16'd199, 1'b1);
      // Two scan passes before one histogram pass, two clear classes.
      send_request(CMD_SCAN, 16'd1000, 1'b1);
      send_request(CMD_SCAN, 16'd3000, 1'b1);
      send_request(CMD_HIST, 16'd1000, 1'b0);
      send_request(CMD_HIST, 16'd1001, 1'b0);
      send_request(CMD_HIST, 16'd2999, 1'b0);
      send_request(CMD_HIST, 16'd3000, 1'b1);

      // Pause the sender until all results are home.
      drain();

      while (requests_sent < 1250) begin
         if (requests_sent > 420 && send_idle_pct == 11) begin
            send_idle_pct = 55;
            rsp_stall_pct = 11;
         end else if (requests_sent > 840 && send_idle_pct == 55) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         kind = $urandom_range(19);
         lo = $urandom_range(65535);
         hi = $urandom_range(65535);
         if (lo > hi) begin
            int t;
            t = lo; lo = hi; hi = t;
         end
         if (kind == 0) begin
            // Stray scan pixels; they widen the next image's extremes.
            send_request(CMD_SCAN, pick(0, 65535), 1'($urandom_range(1)));
         end else if (kind == 1) begin
            send_image(lo, lo, $urandom_range(3), $urandom_range(6, 1), 1);
         end else if (kind == 2) begin
            send_image(lo, hi, 0, $urandom_range(10, 1), 0);
         end else begin
            send_image(lo, hi, $urandom_range(25), $urandom_range(40, 1), 1);
         end
      end

      drain();
      repeat (200) @(posedge clock);

      $display("Covered %0d requests over %0d images, %0d thresholds checked,",
               requests_sent, images_sent, sb.matched);
      $display("with flat, unscanned, out-of-range and single-bin images.");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("otsu_histogram_threshold_core verification clean");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("otsu_histogram_threshold_core verification failed");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("timeout");
      $display("otsu_histogram_threshold_core verification failed");
      $finish;
   end

endmodule
